@@ sv/lbs_pkg.sv @@
package lbs_pkg;

  // Sizes of the joint table and the blend matrix.
  localparam int MAX_JOINTS      = 64;
  localparam int INFL_PER_VERTEX = 8;
  localparam int ELEMS           = 12;
  localparam int TABLE_DEPTH     = MAX_JOINTS * ELEMS;
  localparam int TABLE_AW        = $clog2(TABLE_DEPTH);
  localparam int ELEM_W          = $clog2(ELEMS);
  localparam int CNT_W           = $clog2(INFL_PER_VERTEX + 1);

  // Datapath widths.
  localparam int VAL_W   = 32;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = VAL_W + MUL_B_W;
  localparam int ACC_W   = 48;
  localparam int SUM_W   = 50;

  // Item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_INFL  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [5:0]        joint_index;
    logic [3:0]        matrix_element;
    logic signed [31:0] matrix_value;
    logic [15:0]       weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic              last_influence;
    logic [19:0]       vertex_tag;
  } lbs_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [19:0]       out_tag;
  } lbs_out_t;

  // Control from the sequencer to the blend accumulator.
  typedef struct packed {
    logic              acc_en;
    logic              xf_en;
    logic [ELEM_W-1:0] idx;
    logic [1:0]        row;
    logic              first;
    logic              last;
    logic              clear;
    logic              rd_en;
    logic [ELEM_W-1:0] rd_idx;
  } lbs_blend_ctrl_t;

  // Saturate a 49-bit sum to the 48-bit accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] == v[ACC_W-1]) begin
      r = v[ACC_W-1:0];
    end else if (v[ACC_W]) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate an accumulator element to signed 32 bits.
  function automatic logic signed [VAL_W-1:0] sat_acc32(input logic signed [ACC_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if ((&v[ACC_W-1:VAL_W-1]) || !(|v[ACC_W-1:VAL_W-1])) begin
      r = v[VAL_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a row sum to signed 32 bits.
  function automatic logic signed [VAL_W-1:0] sat_sum32(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if ((&v[SUM_W-1:VAL_W-1]) || !(|v[SUM_W-1:VAL_W-1])) begin
      r = v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ sv/linear_blend_skinning.sv @@
// Linear blend skinning with one shared multiplier.
// Input channel in_valid/in_ready carries lbs_in_t items; output channel
// out_valid/out_ready carries lbs_out_t items. A write item (func 0) stores
// one matrix element in the joint table; the block is ready again in the
// next cycle. An influence item reads the joint's twelve elements one per
// cycle from the table memory and feeds them through the multiplier into
// the blend accumulator, and the block takes no new item until the
// multiplier pipeline has drained. An item that ends a vertex then runs nine
// matrix-by-position products through the same multiplier before its result
// goes to the output register. The multiplier takes one product per cycle.
// Reset clears the accumulator, the influence count and the output valid
// flag; the table is not cleared and must be written before it is used. A
// finished result waits in the output register; the block keeps taking items
// while it waits and only holds at the next result until the receiver takes
// the old one.
module linear_blend_skinning import lbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lbs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lbs_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_ACC_WAIT,
    S_XF,
    S_XF_WAIT,
    S_OUT
  } state_t;

  state_t                   state;
  lbs_in_t                  item;
  logic [TABLE_AW-1:0]      base;
  logic [ELEM_W-1:0]        cnt;
  logic [1:0]               row;
  logic [1:0]               col;
  logic [CNT_W-1:0]         infl_count;
  logic [CNT_W-1:0]         infl_count_next;
  logic                     end_vertex;
  logic                     accept;
  logic                     joint_ok;
  logic                     out_load;

  // Pipeline tags: stage 1 is the multiplier input, stage 2 its output.
  logic                     s1_vld;
  logic                     s1_xf;
  logic [ELEM_W-1:0]        s1_idx;
  logic [1:0]               s1_row;
  logic [1:0]               s1_col;
  logic                     s2_vld;
  logic                     s2_xf;
  logic [ELEM_W-1:0]        s2_idx;
  logic [1:0]               s2_row;
  logic [1:0]               s2_col;

  logic                     ram_we;
  logic [TABLE_AW-1:0]      ram_waddr;
  logic [TABLE_AW-1:0]      ram_raddr;
  logic [VAL_W-1:0]         ram_rdata;
  logic signed [VAL_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [VAL_W-1:0]  pos_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  opa;
  logic signed [VAL_W-1:0]  res_x;
  logic signed [VAL_W-1:0]  res_y;
  logic signed [VAL_W-1:0]  res_z;
  lbs_blend_ctrl_t          bctrl;

  // Input handshake and table writes straight from the input item.
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign joint_ok  = int'(in_data.joint_index) < MAX_JOINTS;
  assign ram_we    = accept && (in_data.func == FUNC_WRITE) && joint_ok &&
                     (int'(in_data.matrix_element) < ELEMS);
  assign ram_waddr = TABLE_AW'(in_data.joint_index) * TABLE_AW'(ELEMS) +
                     TABLE_AW'(in_data.matrix_element);
  assign ram_raddr = base + TABLE_AW'(cnt);
  assign infl_count_next = infl_count + CNT_W'(1);

  // The finished point moves to the output register once it is free.
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  lbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.matrix_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Multiplier operands: table element times weight, or blended element
  // times one position coordinate.
  always_comb begin
    case (s1_col)
      2'd0:    pos_sel = item.pos_x;
      2'd1:    pos_sel = item.pos_y;
      default: pos_sel = item.pos_z;
    endcase
    if (s1_xf) begin
      mul_a = opa;
      mul_b = MUL_B_W'(pos_sel);
    end else begin
      mul_a = signed'(ram_rdata);
      mul_b = signed'({{(MUL_B_W-16){1'b0}}, item.weight});
    end
  end

  lbs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Accumulator control follows the stage 2 tag.
  always_comb begin
    bctrl.acc_en = s2_vld && !s2_xf;
    bctrl.xf_en  = s2_vld && s2_xf;
    bctrl.idx    = s2_idx;
    bctrl.row    = s2_row;
    bctrl.first  = (s2_col == 2'd0);
    bctrl.last   = (s2_col == 2'd2);
    bctrl.clear  = out_load;
    bctrl.rd_en  = (state == S_XF);
    bctrl.rd_idx = ELEM_W'({row, col});
  end

  lbs_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (bctrl),
    .prod  (prod),
    .opa   (opa),
    .res_x (res_x),
    .res_y (res_y),
    .res_z (res_z)
  );

  // Sequencer, pipeline tags and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      infl_count <= '0;
      s1_vld     <= 1'b0;
      s2_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      s1_vld <= (state == S_ACC) || (state == S_XF);
      s2_vld <= s1_vld;
      if (out_load) begin
        out_valid        <= 1'b1;
        out_data.out_x   <= res_x;
        out_data.out_y   <= res_y;
        out_data.out_z   <= res_z;
        out_data.out_tag <= item.vertex_tag;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (in_data.func == FUNC_INFL)) begin
            if (in_data.last_influence ||
                (infl_count_next == CNT_W'(INFL_PER_VERTEX))) begin
              end_vertex <= 1'b1;
              infl_count <= '0;
            end else begin
              end_vertex <= 1'b0;
              infl_count <= infl_count_next;
            end
            cnt <= '0;
            state <= joint_ok ? S_ACC : S_ACC_WAIT;
          end
        end
        S_ACC: begin
          cnt <= cnt + ELEM_W'(1);
          if (cnt == ELEM_W'(ELEMS - 1)) begin
            state <= S_ACC_WAIT;
          end
        end
        S_ACC_WAIT: begin
          if (!s1_vld && !s2_vld) begin
            row   <= 2'd0;
            col   <= 2'd0;
            state <= end_vertex ? S_XF : S_IDLE;
          end
        end
        S_XF: begin
          if (col == 2'd2) begin
            col <= 2'd0;
            row <= row + 2'd1;
            if (row == 2'd2) begin
              state <= S_XF_WAIT;
            end
          end else begin
            col <= col + 2'd1;
          end
        end
        S_XF_WAIT: begin
          if (!s1_vld && !s2_vld) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: latched item, table base and tags.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
      base <= TABLE_AW'(in_data.joint_index) * TABLE_AW'(ELEMS);
    end
    s1_xf  <= (state == S_XF);
    s1_idx <= cnt;
    s1_row <= row;
    s1_col <= (state == S_XF) ? col : 2'd0;
    s2_xf  <= s1_xf;
    s2_idx <= s1_idx;
    s2_row <= s1_row;
    s2_col <= s1_col;
  end

endmodule

@@ sv/lbs_ram.sv @@
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lbs_mul.sv @@
module lbs_mul import lbs_pkg::*; (
  input  logic                      clk,
  input  logic signed [VAL_W-1:0]   a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  p
);

  // The shared signed multiplier, registered at its output.
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ sv/lbs_blend.sv @@
module lbs_blend import lbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  lbs_blend_ctrl_t          ctrl,
  input  logic signed [PROD_W-1:0] prod,
  output logic signed [VAL_W-1:0]  opa,
  output logic signed [VAL_W-1:0]  res_x,
  output logic signed [VAL_W-1:0]  res_y,
  output logic signed [VAL_W-1:0]  res_z
);

  logic signed [ACC_W-1:0] acc [ELEMS];
  logic signed [ACC_W:0]   acc_sum;
  logic signed [SUM_W-1:0] xf_term;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [VAL_W-1:0] res [3];

  // Weighted term floor(m * w / 2^15) added to one element; row sum with the
  // product shifted down by 16, starting from the saturated translation.
  always_comb begin
    acc_sum = (ACC_W+1)'(acc[ctrl.idx]) + signed'(prod[ACC_W+15:15]);
    xf_term = SUM_W'(signed'(prod[PROD_W-2:16]));
    if (ctrl.first) begin
      sum_next = SUM_W'(sat_acc32(acc[ELEM_W'({ctrl.row, 2'b11})])) + xf_term;
    end else begin
      sum_next = sum + xf_term;
    end
  end

  // Blend accumulator, cleared at reset and after each vertex.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < ELEMS; i++) begin
        acc[i] <= '0;
      end
    end else if (ctrl.acc_en) begin
      acc[ctrl.idx] <= sat_acc(acc_sum);
    end
  end

  // Transform operand, running row sum and row results.
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      opa <= sat_acc32(acc[ctrl.rd_idx]);
    end
    if (ctrl.xf_en) begin
      sum <= sum_next;
      if (ctrl.last) begin
        res[ctrl.row] <= sat_sum32(sum_next);
      end
    end
  end

  assign res_x = res[0];
  assign res_y = res[1];
  assign res_z = res[2];

endmodule

@@ sv/lbs_checker.sv @@
module lbs_checker import lbs_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input lbs_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input lbs_out_t out_data
);

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // After a table write the block is ready again in the next cycle.
  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.func == FUNC_WRITE |=> in_ready)
    else $error("not ready after a table write");

  // An influence item occupies the shared multiplier.
  a_infl_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.func == FUNC_INFL |=> !in_ready)
    else $error("ready right after an influence item");

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);
